// ===== rtl/socd_pkg.sv =====
// Shared types and constants for the last-input-priority key resolver.
// Used by socd_lookup and socd_last_input_priority; no dependencies.
`timescale 1ns / 1ps

package socd_pkg;

	// Key codes and the group configuration registers
	localparam int KEY_W          = 8;
	localparam int REG_W          = 32;
	localparam int NUM_GROUP_REGS = 4;
	localparam int KEYS_PER_REG   = REG_W / KEY_W;

	// Default geometry
	localparam int DEFAULT_GROUPS          = 4;
	localparam int DEFAULT_SLOTS_PER_GROUP = 4;

	// Configuration port
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_BYPASS_IDX = CFG_IDX_W'(NUM_GROUP_REGS);

	// No key
	localparam logic [KEY_W-1:0] KEY_NONE = '0;

	// All group registers, group 0 in the lowest word
	typedef logic [NUM_GROUP_REGS-1:0][REG_W-1:0] grp_regs_t;

	// One emitted key transaction
	typedef struct packed {
		logic             synth;
		logic             press;
		logic [KEY_W-1:0] code;
	} key_evt_t;

endpackage

// ===== rtl/socd_last_input_priority.sv =====
// Top level of the last-input-priority key resolver: input register, resolve, result buffer.
// Depends on socd_pkg and socd_lookup.
`timescale 1ns / 1ps

// Resolves opposing keys by last-input-wins. Each key transaction on the s_ side
// is registered, then looked up against the group registers and resolved
// combinationally, and its zero, one or two result transactions are placed in a
// two-entry result buffer. Events that yield at most one result stream at one per
// clock while m_tready is high; an event that yields two results holds the next
// event in the input register until its second result is taken. The last result
// of each event is marked by m_tlast. Code zero, keys in no group and all events
// while bypass is set pass through unchanged. Write configuration only while no
// event is in flight.
module socd_last_input_priority #(
	parameter int GROUPS          = socd_pkg::DEFAULT_GROUPS,
	parameter int SLOTS_PER_GROUP = socd_pkg::DEFAULT_SLOTS_PER_GROUP
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration
	input  logic                            cfg_we,
	input  logic [socd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [socd_pkg::REG_W-1:0]      cfg_wdata,
	// Raw key events
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [socd_pkg::KEY_W-1:0]      s_tdata,  // [7:0] key_code
	input  logic                            s_tuser,  // [0] press
	// Resolved key events
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [socd_pkg::KEY_W-1:0]      m_tdata,  // [7:0] out_key_code
	output logic [1:0]                      m_tuser,  // [0] out_press, [1] synthesized
	output logic                            m_tlast   // last_of_run
);
	import socd_pkg::*;

	localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int SW = $clog2(SLOTS_PER_GROUP);

	// Configuration registers
	grp_regs_t        grp_regs_q;
	logic             bypass_q;

	// Input register
	logic             valid_s1;
	logic [KEY_W-1:0] code_s1;
	logic             press_s1;

	// Resolver state
	logic [GROUPS-1:0][SLOTS_PER_GROUP-1:0] held_q;
	logic [KEY_W-1:0] active_q [GROUPS];
	logic [KEY_W-1:0] prev_q   [GROUPS];

	// Result buffer
	key_evt_t         out0_q;
	key_evt_t         out1_q;
	logic [1:0]       out_cnt_q;

	// Lookup and resolve
	logic             hit;
	logic [GW-1:0]    grp;
	logic [SW-1:0]    slot;
	logic             grouped;
	logic [KEY_W-1:0] cur_active;
	logic [KEY_W-1:0] cur_prev;
	logic             cur_held;
	logic [KEY_W-1:0] nxt_active;
	logic [KEY_W-1:0] nxt_prev;
	logic             nxt_held;
	key_evt_t         res0;
	key_evt_t         res1;
	logic [1:0]       res_cnt;

	logic             pop;
	logic             advance;

	// Hold configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_regs_q <= '0;
			bypass_q   <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index < CFG_BYPASS_IDX) begin
				grp_regs_q[cfg_index[$clog2(NUM_GROUP_REGS)-1:0]] <= cfg_wdata;
			end else if (cfg_index == CFG_BYPASS_IDX) begin
				bypass_q <= cfg_wdata[0];
			end
		end
	end

	// Handshake: resolve when the buffer is free or drains its last entry now
	assign pop      = m_tvalid & m_tready;
	assign advance  = (out_cnt_q == 2'd0) || (out_cnt_q == 2'd1 && pop);
	assign s_tready = !valid_s1 || advance;

	// Register the accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			code_s1  <= s_tdata;
			press_s1 <= s_tuser;
		end
	end

	socd_lookup #(
		.GROUPS          (GROUPS),
		.SLOTS_PER_GROUP (SLOTS_PER_GROUP),
		.GW              (GW),
		.SW              (SW)
	) u_lookup (
		.regs (grp_regs_q),
		.code (code_s1),
		.hit  (hit),
		.grp  (grp),
		.slot (slot)
	);

	assign grouped    = hit && !bypass_q;
	assign cur_active = active_q[grp];
	assign cur_prev   = prev_q[grp];
	assign cur_held   = held_q[grp][slot];

	// Resolve one event against its group's state
	always_comb begin
		nxt_active = cur_active;
		nxt_prev   = cur_prev;
		nxt_held   = cur_held;
		res0       = '{synth: 1'b0, press: press_s1, code: code_s1};
		res1       = '{synth: 1'b1, press: 1'b0, code: cur_active};
		res_cnt    = 2'd1;
		if (grouped) begin
			if (press_s1) begin
				if (cur_held) begin
					res_cnt = 2'd0;
				end else begin
					nxt_held   = 1'b1;
					nxt_active = code_s1;
					if (cur_active != KEY_NONE && cur_active != code_s1) begin
						// Release the key this press overrides
						nxt_prev = cur_active;
						res_cnt  = 2'd2;
					end
				end
			end else begin
				if (!cur_held) begin
					res_cnt = 2'd0;
					if (cur_prev == code_s1) begin
						nxt_prev = KEY_NONE;
					end
				end else begin
					nxt_held = 1'b0;
					nxt_prev = KEY_NONE;
					if (cur_active == code_s1 && cur_prev != KEY_NONE) begin
						// Press the remembered key again
						nxt_active = cur_prev;
						res1       = '{synth: 1'b1, press: 1'b1, code: cur_prev};
						res_cnt    = 2'd2;
					end else if (cur_active == code_s1) begin
						nxt_active = KEY_NONE;
					end
				end
			end
		end
	end

	// Commit group state when the event leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			for (int g = 0; g < GROUPS; g++) begin
				active_q[g] <= KEY_NONE;
				prev_q[g]   <= KEY_NONE;
			end
		end else if (valid_s1 && advance && grouped) begin
			held_q[grp][slot] <= nxt_held;
			active_q[grp]     <= nxt_active;
			prev_q[grp]       <= nxt_prev;
		end
	end

	// Load fresh results or advance the buffer by one transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= 2'd0;
		end else if (valid_s1 && advance) begin
			out_cnt_q <= res_cnt;
		end else if (pop) begin
			out_cnt_q <= out_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			out0_q <= res0;
			out1_q <= res1;
		end else if (pop) begin
			out0_q <= out1_q;
		end
	end

	assign m_tvalid = (out_cnt_q != 2'd0);
	assign m_tdata  = out0_q.code;
	assign m_tuser  = {out0_q.synth, out0_q.press};
	assign m_tlast  = (out_cnt_q == 2'd1);

endmodule

// ===== rtl/socd_lookup.sv =====
// Key code to group/slot lookup over the configured group registers.
// Depends on socd_pkg; the lowest group, then lowest slot, owns a duplicated code.
`timescale 1ns / 1ps

module socd_lookup #(
	parameter int GROUPS          = socd_pkg::DEFAULT_GROUPS,
	parameter int SLOTS_PER_GROUP = socd_pkg::DEFAULT_SLOTS_PER_GROUP,
	parameter int GW              = (GROUPS > 1) ? $clog2(GROUPS) : 1,
	parameter int SW              = $clog2(SLOTS_PER_GROUP)
) (
	input  socd_pkg::grp_regs_t          regs,
	input  logic [socd_pkg::KEY_W-1:0]   code,
	output logic                         hit,
	output logic [GW-1:0]                grp,
	output logic [SW-1:0]                slot
);
	import socd_pkg::*;

	logic [KEY_W-1:0] code_tab [GROUPS][SLOTS_PER_GROUP];

	// Map each slot to its register byte; slots without register bits stay unused
	for (genvar g = 0; g < GROUPS; g++) begin : g_grp
		for (genvar s = 0; s < SLOTS_PER_GROUP; s++) begin : g_slot
			if (g < NUM_GROUP_REGS && s < KEYS_PER_REG) begin : g_cfg
				assign code_tab[g][s] = regs[g][s*KEY_W +: KEY_W];
			end else begin : g_unused
				assign code_tab[g][s] = KEY_NONE;
			end
		end
	end

	// Scan from the top so the lowest matching slot is taken last
	always_comb begin
		hit  = 1'b0;
		grp  = '0;
		slot = '0;
		for (int g = GROUPS - 1; g >= 0; g--) begin
			for (int s = SLOTS_PER_GROUP - 1; s >= 0; s--) begin
				if (code != KEY_NONE && code_tab[g][s] == code) begin
					hit  = 1'b1;
					grp  = GW'(g);
					slot = SW'(s);
				end
			end
		end
	end

endmodule
